// ===== sv/sleep_wake_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// sleep wake sequencer assertion macros
// shared concurrent checks on i_clk, with or without the reset guard
// ----------------------------------------------------------------------------
`ifndef SLEEP_WAKE_SEQUENCER_DEFINES_SVH
`define SLEEP_WAKE_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SWSQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, not disabled by reset
`define SWSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/swsq_pkg.sv =====
// ----------------------------------------------------------------------------
// sleep wake sequencer package
// widths, codes, payload structs and phase helpers
// ----------------------------------------------------------------------------
package swsq_pkg;

    localparam int NUM_LINES  = 3;
    localparam int TIME_W     = 32;
    localparam int SEC_W      = 32;
    localparam int MASK_W     = 3;
    localparam int EIGHT_W    = 29;
    localparam int SMALL_W    = 3;
    localparam int REASON_W   = 3;
    localparam int CMD_W      = 2;
    localparam int LINE_W     = 2;
    localparam int PERIOD_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_EDGE  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_UNTIMED = 3'd1,
        PH_EIGHT   = 3'd2,
        PH_FOUR    = 3'd3,
        PH_TWO     = 3'd4,
        PH_ONE     = 3'd5
    } t_phase;

    localparam logic [REASON_W-1:0] REASON_NONE  = 3'd0;
    localparam logic [REASON_W-1:0] REASON_TIMER = 3'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_S   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN0 = 3'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [LINE_W-1:0] line_index;
        logic              pin_level;
        logic [TIME_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic                asleep;
        logic                program_watchdog;
        logic [PERIOD_W-1:0] period_select;
        logic                woke;
        logic [REASON_W-1:0] wake_reason;
        logic                suppressed;
    } t_result;

    typedef struct packed {
        logic                              timer_wake_enabled;
        logic [SEC_W-1:0]                  sleep_seconds;
        logic [MASK_W-1:0]                 line_enable_mask;
        logic [NUM_LINES-1:0][TIME_W-1:0]  cooldown_ms;
    } t_cfg;

    // edge classification handed from line history to the phase sequencer
    typedef struct packed {
        logic assigned;
        logic suppressed;
    } t_edge_info;

    function automatic t_phase first_phase(input logic [EIGHT_W-1:0] eight,
                                           input logic [SMALL_W-1:0] small_left);
        t_phase p;
        if (eight != '0) begin
            p = PH_EIGHT;
        end else if (small_left[2]) begin
            p = PH_FOUR;
        end else if (small_left[1]) begin
            p = PH_TWO;
        end else if (small_left[0]) begin
            p = PH_ONE;
        end else begin
            p = PH_IDLE;
        end
        return p;
    endfunction

    function automatic logic is_timed(input t_phase p);
        return (p == PH_EIGHT) || (p == PH_FOUR) || (p == PH_TWO) || (p == PH_ONE);
    endfunction

endpackage

// ===== sv/swsq_if.sv =====
// ----------------------------------------------------------------------------
// sleep wake sequencer channels
// valid/ready interfaces for items, results and register writes
// ----------------------------------------------------------------------------
interface swsq_item_if;
    logic                        valid;
    logic                        ready;
    logic [swsq_pkg::CMD_W-1:0]  cmd;
    logic [swsq_pkg::LINE_W-1:0] line_index;
    logic                        pin_level;
    logic [swsq_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, cmd, line_index, pin_level, now_ms, input ready);
    modport sink   (input valid, cmd, line_index, pin_level, now_ms, output ready);
endinterface

interface swsq_result_if;
    logic                          valid;
    logic                          ready;
    logic                          asleep;
    logic                          program_watchdog;
    logic [swsq_pkg::PERIOD_W-1:0] period_select;
    logic                          woke;
    logic [swsq_pkg::REASON_W-1:0] wake_reason;
    logic                          suppressed;

    modport source (output valid, asleep, program_watchdog, period_select, woke,
                    wake_reason, suppressed, input ready);
    modport sink   (input valid, asleep, program_watchdog, period_select, woke,
                    wake_reason, suppressed, output ready);
endinterface

interface swsq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [swsq_pkg::CFG_IDX_W-1:0]  index;
    logic [swsq_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/swsq_cfg.sv =====
// ----------------------------------------------------------------------------
// sleep wake sequencer configuration registers
// register file with per-line history clear on cooldown writes
// ----------------------------------------------------------------------------
module swsq_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    swsq_cfg_if.sink                           i_cfg,
    output swsq_pkg::t_cfg                     o_cfg,
    output logic [swsq_pkg::NUM_LINES-1:0]     o_clear
);

    swsq_pkg::t_cfg r_cfg;
    logic           w_wr;

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid && i_cfg.ready;
    assign o_cfg       = r_cfg;

    // cooldown write also wipes that line's history
    always_comb begin
        for (int i = 0; i < swsq_pkg::NUM_LINES; i++) begin
            o_clear[i] = w_wr &&
                (i_cfg.index == swsq_pkg::CFG_IDX_W'(swsq_pkg::CFG_COOLDOWN0 + i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            if (i_cfg.index == swsq_pkg::CFG_TIMER_EN) begin
                r_cfg.timer_wake_enabled <= i_cfg.data[0];
            end
            if (i_cfg.index == swsq_pkg::CFG_SLEEP_S) begin
                r_cfg.sleep_seconds <= i_cfg.data[swsq_pkg::SEC_W-1:0];
            end
            if (i_cfg.index == swsq_pkg::CFG_LINE_MASK) begin
                r_cfg.line_enable_mask <= i_cfg.data[swsq_pkg::MASK_W-1:0];
            end
            for (int i = 0; i < swsq_pkg::NUM_LINES; i++) begin
                if (o_clear[i]) begin
                    r_cfg.cooldown_ms[i] <= i_cfg.data[swsq_pkg::TIME_W-1:0];
                end
            end
        end
    end

endmodule

// ===== sv/swsq_line_hist.sv =====
// ----------------------------------------------------------------------------
// sleep wake sequencer line history
// last accepted wake time per line and the cooldown check
// ----------------------------------------------------------------------------
module swsq_line_hist (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic                           i_active,
    input  swsq_pkg::t_item                i_item,
    input  swsq_pkg::t_cfg                 i_cfg,
    input  logic [swsq_pkg::NUM_LINES-1:0] i_clear,
    output swsq_pkg::t_edge_info           o_edge
);

    logic [swsq_pkg::TIME_W-1:0] r_last [swsq_pkg::NUM_LINES];
    logic [swsq_pkg::NUM_LINES-1:0] r_has;

    logic [swsq_pkg::TIME_W-1:0] w_cd;
    logic [swsq_pkg::TIME_W-1:0] w_last;
    logic [swsq_pkg::TIME_W-1:0] w_elapsed;
    logic                        w_has;
    logic                        w_assigned;
    logic                        w_supp;
    logic                        w_record;

    // pick the addressed line's settings and history
    always_comb begin
        w_cd       = '0;
        w_last     = '0;
        w_has      = 1'b0;
        w_assigned = 1'b0;
        for (int i = 0; i < swsq_pkg::NUM_LINES; i++) begin
            if (i_item.line_index == swsq_pkg::LINE_W'(i)) begin
                w_cd   = i_cfg.cooldown_ms[i];
                w_last = r_last[i];
                w_has  = r_has[i];
                if (i < swsq_pkg::MASK_W) begin
                    w_assigned = i_cfg.line_enable_mask[i];
                end
            end
        end
    end

    // wraparound elapsed time
    assign w_elapsed = i_item.now_ms - w_last;
    assign w_supp    = (w_cd != '0) && w_has && (w_elapsed < w_cd);
    assign w_record  = i_advance && i_active && (i_item.cmd == swsq_pkg::CMD_EDGE) &&
                       w_assigned && (w_cd != '0) && !w_supp;

    assign o_edge.assigned   = (i_item.cmd == swsq_pkg::CMD_EDGE) && w_assigned;
    assign o_edge.suppressed = w_supp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has <= '0;
        end else begin
            for (int i = 0; i < swsq_pkg::NUM_LINES; i++) begin
                if (i_clear[i]) begin
                    r_has[i] <= 1'b0;
                end else if (w_record && (i_item.line_index == swsq_pkg::LINE_W'(i))) begin
                    r_has[i] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < swsq_pkg::NUM_LINES; i++) begin
            if (w_record && (i_item.line_index == swsq_pkg::LINE_W'(i))) begin
                r_last[i] <= i_item.now_ms;
            end
        end
    end

endmodule

// ===== sv/swsq_plan.sv =====
// ----------------------------------------------------------------------------
// sleep wake sequencer phase control
// chunk counters, phase state and the result of each item
// ----------------------------------------------------------------------------
module swsq_plan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  swsq_pkg::t_item      i_item,
    input  swsq_pkg::t_cfg       i_cfg,
    input  swsq_pkg::t_edge_info i_edge,
    output logic                 o_active,
    output swsq_pkg::t_result    o_result
);

    swsq_pkg::t_phase                 r_phase;
    swsq_pkg::t_phase                 n_phase;
    logic [swsq_pkg::EIGHT_W-1:0]     r_eight;
    logic [swsq_pkg::EIGHT_W-1:0]     n_eight;
    logic [swsq_pkg::SMALL_W-1:0]     r_small;
    logic [swsq_pkg::SMALL_W-1:0]     n_small;

    logic                             w_start;
    logic                             w_tick;
    logic                             w_edge;
    logic                             w_edge_wake;
    logic                             w_use_chunk;
    logic [swsq_pkg::EIGHT_W-1:0]     w_eight_dec;
    logic [swsq_pkg::SMALL_W-1:0]     w_small_dec;
    swsq_pkg::t_phase                 w_chunk_phase;
    swsq_pkg::t_phase                 w_start_phase;
    logic [2:0]                       w_ph_off;

    assign o_active = (r_phase != swsq_pkg::PH_IDLE);

    assign w_start     = (i_item.cmd == swsq_pkg::CMD_START);
    assign w_tick      = (i_item.cmd == swsq_pkg::CMD_TICK);
    assign w_edge      = (i_item.cmd == swsq_pkg::CMD_EDGE);
    assign w_edge_wake = o_active && i_edge.assigned && !i_edge.suppressed;
    // during a timed phase, ticks, unassigned edges and suppressed edges all use up a chunk
    assign w_use_chunk = swsq_pkg::is_timed(r_phase) &&
                         (w_tick || (w_edge && (!i_edge.assigned || i_edge.suppressed)));

    assign w_start_phase = swsq_pkg::first_phase(
        i_cfg.sleep_seconds[swsq_pkg::SEC_W-1:3], i_cfg.sleep_seconds[2:0]);

    always_comb begin
        w_eight_dec = r_eight;
        w_small_dec = r_small;
        case (r_phase)
            swsq_pkg::PH_EIGHT: w_eight_dec = r_eight - 1'b1;
            swsq_pkg::PH_FOUR:  w_small_dec = r_small & 3'b011;
            swsq_pkg::PH_TWO:   w_small_dec = r_small & 3'b101;
            default:            w_small_dec = r_small & 3'b110;
        endcase
    end

    assign w_chunk_phase = swsq_pkg::first_phase(w_eight_dec, w_small_dec);

    // next state
    always_comb begin
        n_phase = r_phase;
        n_eight = r_eight;
        n_small = r_small;
        if (w_start) begin
            if (i_cfg.timer_wake_enabled) begin
                n_eight = i_cfg.sleep_seconds[swsq_pkg::SEC_W-1:3];
                n_small = i_cfg.sleep_seconds[2:0];
                n_phase = w_start_phase;
            end else begin
                n_eight = '0;
                n_small = '0;
                n_phase = swsq_pkg::PH_UNTIMED;
            end
        end else if (w_edge_wake) begin
            n_eight = '0;
            n_small = '0;
            n_phase = swsq_pkg::PH_IDLE;
        end else if (w_use_chunk) begin
            n_eight = w_eight_dec;
            n_small = w_small_dec;
            n_phase = w_chunk_phase;
        end else if (!o_active || !swsq_pkg::is_timed(r_phase)) begin
            // stray codes fall back to idle, untimed stays as it is
            n_phase = (r_phase == swsq_pkg::PH_UNTIMED) ? swsq_pkg::PH_UNTIMED
                                                       : swsq_pkg::PH_IDLE;
        end
    end

    assign w_ph_off = 3'(n_phase) - 3'(swsq_pkg::PH_EIGHT);

    // outputs
    always_comb begin
        o_result                  = '0;
        o_result.asleep           = (n_phase != swsq_pkg::PH_IDLE);
        o_result.period_select    = swsq_pkg::is_timed(n_phase) ? w_ph_off[1:0] : '0;
        o_result.suppressed       = o_active && i_edge.assigned && i_edge.suppressed;
        if (w_start) begin
            if (i_cfg.timer_wake_enabled) begin
                o_result.woke             = (w_start_phase == swsq_pkg::PH_IDLE);
                o_result.program_watchdog = (w_start_phase != swsq_pkg::PH_IDLE);
            end
        end else if (w_edge_wake) begin
            o_result.woke        = 1'b1;
            o_result.wake_reason = {i_item.line_index + 1'b1, i_item.pin_level};
        end else if (w_use_chunk) begin
            o_result.program_watchdog = (w_chunk_phase != r_phase) &&
                                        (w_chunk_phase != swsq_pkg::PH_IDLE);
            if (w_chunk_phase == swsq_pkg::PH_IDLE) begin
                o_result.woke        = 1'b1;
                o_result.wake_reason = w_tick ? swsq_pkg::REASON_TIMER
                                              : swsq_pkg::REASON_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= swsq_pkg::PH_IDLE;
            r_eight <= '0;
            r_small <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_eight <= n_eight;
            r_small <= n_small;
        end
    end

endmodule

// ===== sv/sleep_wake_sequencer.sv =====
// ----------------------------------------------------------------------------
// sleep wake sequencer top level
// path: input register, then result register, from input transfer to result valid
// throughput: one item per cycle while the result register is free or being drained
// reset: synchronous active low, clears phase, counters, history and registers
// ----------------------------------------------------------------------------
`include "sleep_wake_sequencer_defines.svh"

module sleep_wake_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    swsq_item_if.sink     i_item,
    swsq_result_if.source o_result,
    swsq_cfg_if.sink      i_cfg
);

    // input stage
    logic                           r_in_valid;
    swsq_pkg::t_item                r_in;

    // result stage
    logic                           r_out_valid;
    swsq_pkg::t_result              r_out;

    // internal links
    logic                           w_advance;
    logic                           w_active;
    swsq_pkg::t_cfg                 w_cfg;
    logic [swsq_pkg::NUM_LINES-1:0] w_clear;
    swsq_pkg::t_edge_info           w_edge;
    swsq_pkg::t_result              w_result;

    // an item moves on whenever the result register is free or being drained,
    // so a waiting result only holds off input transfers once the input
    // register is full as well
    assign w_advance    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.cmd        <= i_item.cmd;
            r_in.line_index <= i_item.line_index;
            r_in.pin_level  <= i_item.pin_level;
            r_in.now_ms     <= i_item.now_ms;
        end
    end

    // register file, cooldown writes clear line history
    swsq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg),
        .o_clear (w_clear)
    );

    // cooldown check and last-wake bookkeeping per line
    swsq_line_hist u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_active  (w_active),
        .i_item    (r_in),
        .i_cfg     (w_cfg),
        .i_clear   (w_clear),
        .o_edge    (w_edge)
    );

    // phase sequencing and result forming
    swsq_plan u_plan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_in),
        .i_cfg     (w_cfg),
        .i_edge    (w_edge),
        .o_active  (w_active),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.asleep           = r_out.asleep;
    assign o_result.program_watchdog = r_out.program_watchdog;
    assign o_result.period_select    = r_out.period_select;
    assign o_result.woke             = r_out.woke;
    assign o_result.wake_reason      = r_out.wake_reason;
    assign o_result.suppressed       = r_out.suppressed;

    // a wake always leaves the block awake
    `SWSQ_ASSERT_IMPL(a_wake_ends_sleep, r_out_valid && r_out.woke, !r_out.asleep,
        "wake while asleep")
    // a reason code only travels with a wake
    `SWSQ_ASSERT_IMPL(a_reason_with_wake,
        r_out_valid && (r_out.wake_reason != swsq_pkg::REASON_NONE), r_out.woke,
        "reason without wake")
    // reprogramming only happens for a timed phase that continues
    `SWSQ_ASSERT_IMPL(a_prog_timed, r_out_valid && r_out.program_watchdog,
        r_out.asleep && !r_out.woke, "watchdog reprogram while not sleeping")
    // reset empties both stages
    `SWSQ_ASSERT_NEXT(a_reset_empty, !i_rst_n, !r_in_valid && !r_out_valid,
        "pipeline not empty after reset")

endmodule
